FILE: hw/rtl/fac_pkg.sv
// ---------------------------------------------------------------------------
// fac_pkg
// Types and codes for the binary32 accumulator calculator.
// ---------------------------------------------------------------------------
`default_nettype none

package fac_pkg;

    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_SET  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DIV0    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CMD = 2'd2;

    localparam logic [WORD_W-1:0] CANON_NAN = 32'h7FC0_0000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] operand;
    } t_in_req;

    typedef struct packed {
        logic [WORD_W-1:0]   acc_value;
        logic [STATUS_W-1:0] status;
    } t_out_req;

endpackage

`default_nettype wire

FILE: hw/rtl/float_accumulator_alu.sv
// ---------------------------------------------------------------------------
// float_accumulator_alu
// Binary32 accumulator with set, add, subtract, multiply, divide and read.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry a request {cmd, operand}.
//   Output channel: o_out_valid / i_out_stall carry {acc_value, status}.
//   Every request yields exactly one output request.
//   A request is taken only while the sequencer is idle; o_in_stall is high
//   from the cycle after acceptance until the result is written to the
//   output register. A pending output does not block acceptance.
//   Steps from acceptance to the load of the output register:
//   set, read, invalid commands and special operands: straight to done.
//   Add/subtract: alignment shift (up to 49), normalization, rounding.
//   Multiply: prescale (0-23), shift-add iterations, normalization, rounding.
//   Divide: prescale (0-23), restoring iterations, normalization, rounding.
//   The next request can be taken in the cycle after the output load.
//   The run time is set by the one-bit-per-cycle shifter and the shared
//   add/subtract datapath.
//   Reset clears the accumulator to +0.0 and drops any pending output.
//   If the receiver stalls, the finished result waits in the sequencer
//   until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module float_accumulator_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire fac_pkg::t_in_req  i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output fac_pkg::t_out_req      o_out_req
);
    import fac_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ALIGN = 3'd4;
    localparam logic [2:0] S_NORM  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [WORD_W-1:0]   r_acc, n_acc;
    logic [STATUS_W-1:0] r_stat, n_stat;
    logic                r_sign, n_sign;
    logic                r_subop, n_subop;
    logic signed [10:0]  r_e, n_e;
    logic signed [10:0]  r_ea, n_ea;
    logic signed [10:0]  r_eb, n_eb;
    logic [49:0]         r_m, n_m;
    logic [49:0]         r_x, n_x;
    logic [23:0]         r_ma, n_ma;
    logic [23:0]         r_mb, n_mb;
    logic [23:0]         r_hi, n_hi;
    logic [25:0]         r_rem, n_rem;
    logic [7:0]          r_d, n_d;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_out_valid;
    t_out_req            r_out;

    logic        in_acc, out_load;
    logic        sa, sb, sbe, sx;
    logic [7:0]  a_exp, b_exp;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic signed [10:0] ea_u, eb_u;
    logic [23:0] ma_u, mb_u;
    logic [24:0] mul_sum;
    logic        div_ge;
    logic [25:0] div_diff;
    logic [23:0] rnd_sig, rnd_sig2;
    logic        rnd_inc;
    logic [24:0] rnd_s25;
    logic signed [10:0] rnd_e2;
    logic [WORD_W-1:0]  rnd_word;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign a_exp  = r_acc[30:23];
    assign b_exp  = i_in_req.operand[30:23];
    assign sa     = r_acc[31];
    assign sb     = i_in_req.operand[31];
    assign sbe    = sb ^ (i_in_req.cmd == CMD_SUB);
    assign sx     = sa ^ sb;
    assign a_nan  = (a_exp == 8'hFF) && (r_acc[22:0] != 23'd0);
    assign b_nan  = (b_exp == 8'hFF) && (i_in_req.operand[22:0] != 23'd0);
    assign a_inf  = (a_exp == 8'hFF) && (r_acc[22:0] == 23'd0);
    assign b_inf  = (b_exp == 8'hFF) && (i_in_req.operand[22:0] == 23'd0);
    assign a_zero = (r_acc[30:0] == 31'd0);
    assign b_zero = (i_in_req.operand[30:0] == 31'd0);
    assign ea_u   = (a_exp == 8'd0) ? 11'sd1 : $signed({3'b000, a_exp});
    assign eb_u   = (b_exp == 8'd0) ? 11'sd1 : $signed({3'b000, b_exp});
    assign ma_u   = {a_exp != 8'd0, r_acc[22:0]};
    assign mb_u   = {b_exp != 8'd0, i_in_req.operand[22:0]};

    assign mul_sum  = {1'b0, r_hi} + (r_mb[0] ? {1'b0, r_ma} : 25'd0);
    assign div_ge   = r_rem >= {2'b00, r_mb};
    assign div_diff = r_rem - (div_ge ? {2'b00, r_mb} : 26'd0);

    // round to nearest even from the normalized working mantissa
    always_comb begin
        rnd_sig = r_m[48:25];
        rnd_inc = r_m[24] && ((|r_m[23:0]) || rnd_sig[0]);
        rnd_s25 = {1'b0, rnd_sig} + {24'd0, rnd_inc};
        if (rnd_s25[24]) begin
            rnd_sig2 = rnd_s25[24:1];
            rnd_e2   = r_e + 11'sd1;
        end else begin
            rnd_sig2 = rnd_s25[23:0];
            rnd_e2   = r_e;
        end
        if (rnd_e2 >= 11'sd255) begin
            rnd_word = {r_sign, 8'hFF, 23'd0};
        end else if (rnd_sig2[23]) begin
            rnd_word = {r_sign, rnd_e2[7:0], rnd_sig2[22:0]};
        end else begin
            rnd_word = {r_sign, 8'd0, rnd_sig2[22:0]};
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_acc   = r_acc;
        n_stat  = r_stat;
        n_sign  = r_sign;
        n_subop = r_subop;
        n_e     = r_e;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_m     = r_m;
        n_x     = r_x;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_hi    = r_hi;
        n_rem   = r_rem;
        n_d     = r_d;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_in_req.cmd;
                    n_stat  = STATUS_OK;
                    n_state = S_DONE;
                    n_ma    = ma_u;
                    n_mb    = mb_u;
                    n_ea    = ea_u;
                    n_eb    = eb_u;
                    n_sign  = sx;
                    case (i_in_req.cmd)
                        CMD_SET: n_acc = i_in_req.operand;
                        CMD_READ: n_acc = r_acc;
                        CMD_ADD, CMD_SUB: begin
                            if (a_nan || b_nan) begin
                                n_acc = CANON_NAN;
                            end else if (a_inf && b_inf && (sa != sbe)) begin
                                n_acc = CANON_NAN;
                            end else if (a_inf) begin
                                n_acc = r_acc;
                            end else if (b_inf) begin
                                n_acc = {sbe, i_in_req.operand[30:0]};
                            end else if (a_zero && b_zero) begin
                                n_acc = {sa && sbe, 31'd0};
                            end else begin
                                n_subop = sa != sbe;
                                n_state = S_ALIGN;
                                if (eb_u > ea_u) begin
                                    n_m    = {1'b0, mb_u, 25'd0};
                                    n_x    = {1'b0, ma_u, 25'd0};
                                    n_e    = eb_u;
                                    n_d    = 8'(eb_u - ea_u);
                                    n_sign = sbe;
                                end else begin
                                    n_m    = {1'b0, ma_u, 25'd0};
                                    n_x    = {1'b0, mb_u, 25'd0};
                                    n_e    = ea_u;
                                    n_d    = 8'(ea_u - eb_u);
                                    n_sign = sa;
                                end
                            end
                        end
                        CMD_MUL: begin
                            if (a_nan || b_nan) begin
                                n_acc = CANON_NAN;
                            end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                                n_acc = CANON_NAN;
                            end else if (a_inf || b_inf) begin
                                n_acc = {sx, 8'hFF, 23'd0};
                            end else if (a_zero || b_zero) begin
                                n_acc = {sx, 31'd0};
                            end else begin
                                n_state = S_PREP;
                            end
                        end
                        CMD_DIV: begin
                            if (b_zero) begin
                                n_stat = STATUS_DIV0;
                            end else if (a_nan || b_nan || (a_inf && b_inf)) begin
                                n_acc = CANON_NAN;
                            end else if (a_inf) begin
                                n_acc = {sx, 8'hFF, 23'd0};
                            end else if (b_inf || a_zero) begin
                                n_acc = {sx, 31'd0};
                            end else begin
                                n_state = S_PREP;
                            end
                        end
                        default: n_stat = STATUS_BAD_CMD;
                    endcase
                end
            end
            S_PREP: begin
                if (!r_ma[23]) begin
                    n_ma = {r_ma[22:0], 1'b0};
                    n_ea = r_ea - 11'sd1;
                end
                if (!r_mb[23]) begin
                    n_mb = {r_mb[22:0], 1'b0};
                    n_eb = r_eb - 11'sd1;
                end
                if (r_ma[23] && r_mb[23]) begin
                    if (r_cmd == CMD_MUL) begin
                        n_e     = r_ea + r_eb - 11'sd127;
                        n_hi    = 24'd0;
                        n_cnt   = 5'd24;
                        n_state = S_MUL;
                    end else begin
                        n_e     = r_ea - r_eb + 11'sd127;
                        n_rem   = {2'b00, r_ma};
                        n_x     = 50'd0;
                        n_cnt   = 5'd27;
                        n_state = S_DIV;
                    end
                end
            end
            S_MUL: begin
                if (r_cnt == 5'd0) begin
                    n_m     = {r_hi, r_mb, 2'b00};
                    n_state = S_NORM;
                end else begin
                    n_hi  = mul_sum[24:1];
                    n_mb  = {mul_sum[0], r_mb[23:1]};
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_DIV: begin
                if (r_cnt == 5'd0) begin
                    n_m     = {1'b0, r_x[26:0], 21'd0, r_rem != 26'd0};
                    n_state = S_NORM;
                end else begin
                    n_rem = {div_diff[24:0], 1'b0};
                    n_x   = {r_x[48:0], div_ge};
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_ALIGN: begin
                if (r_d == 8'd0) begin
                    n_state = S_NORM;
                    if (!r_subop) begin
                        n_m = r_m + r_x;
                    end else if (r_m >= r_x) begin
                        n_m = r_m - r_x;
                        if (r_m == r_x) begin
                            n_sign = 1'b0;
                        end
                    end else begin
                        n_m    = r_x - r_m;
                        n_sign = !r_sign;
                    end
                end else if (r_d > 8'd49) begin
                    n_x = {49'd0, r_x != 50'd0};
                    n_d = 8'd0;
                end else begin
                    n_x = {1'b0, r_x[49:1]} | {49'd0, r_x[0]};
                    n_d = r_d - 8'd1;
                end
            end
            S_NORM: begin
                if (r_m[49]) begin
                    n_m = {1'b0, r_m[49:1]} | {49'd0, r_m[0]};
                    n_e = r_e + 11'sd1;
                end else if (r_e < 11'sd1) begin
                    if (r_e < -11'sd60) begin
                        n_m = {49'd0, r_m != 50'd0};
                        n_e = 11'sd1;
                    end else begin
                        n_m = {1'b0, r_m[49:1]} | {49'd0, r_m[0]};
                        n_e = r_e + 11'sd1;
                    end
                end else if (!r_m[48] && (r_e > 11'sd1) && (r_m != 50'd0)) begin
                    n_m = {r_m[48:0], 1'b0};
                    n_e = r_e - 11'sd1;
                end else begin
                    n_acc   = (rnd_word[30:23] == 8'hFF) ? {r_sign, 8'hFF, 23'd0}
                                                         : rnd_word;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_stat  <= n_stat;
        r_sign  <= n_sign;
        r_subop <= n_subop;
        r_e     <= n_e;
        r_ea    <= n_ea;
        r_eb    <= n_eb;
        r_m     <= n_m;
        r_x     <= n_x;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_hi    <= n_hi;
        r_rem   <= n_rem;
        r_d     <= n_d;
        r_cnt   <= n_cnt;
        if (out_load) begin
            r_out.acc_value <= r_acc;
            r_out.status    <= r_stat;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("sequencer not busy after accepting a request");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("output loaded outside the done step");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.status != 2'd3)
        else $error("undefined status code");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_DIV) |-> r_cnt <= 5'd27)
        else $error("iteration count out of range");

endmodule

`default_nettype wire

FILE: test/float_accumulator_alu_test.sv
// ---------------------------------------------------------------------------
// float_accumulator_alu_test
// Drives set/add/sub/mul/div/read/invalid requests and checks every result
// against a bit-exact binary32 predictor built on wide integer arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

module float_accumulator_alu_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fac_pkg::*;

    localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;
    localparam int N_RANDOM    = 2000;
    localparam int CYCLE_LIMIT = 3000000;

    typedef logic [319:0] t_wide;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in_req = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out_req;

    t_in_req  cmd_queue[$];
    t_out_req result_queue[$];
    logic [WORD_W-1:0] acc_model = '0;
    int errors = 0;
    int cycles = 0;
    int issued = 0;
    int tx_idle_pct = 33;
    int rx_idle_pct = 51;
    logic o_in_stall_at_edge = 1'b1;

    float_accumulator_alu dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_req(i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_req(o_out_req)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic is_nan(logic [31:0] x);
        return (&x[30:23]) && (|x[22:0]);
    endfunction

    function automatic logic is_inf(logic [31:0] x);
        return (&x[30:23]) && !(|x[22:0]);
    endfunction

    function automatic logic is_zero(logic [31:0] x);
        return x[30:0] == '0;
    endfunction

    function automatic void fp_split(input logic [31:0] x, output t_wide m, output int e);
        if (x[30:23] == 8'd0) begin
            m = t_wide'(x[22:0]);
            e = -149;
        end else begin
            m = t_wide'({1'b1, x[22:0]});
            e = int'(x[30:23]) - 150;
        end
    endfunction

    // value = m * 2^e, m nonzero; round to nearest even into binary32
    function automatic logic [31:0] fp_round(logic s, t_wide m, int e);
        int p;
        int sh;
        int qe;
        t_wide q;
        logic g;
        logic st;
        p = 0;
        for (int i = 0; i < 320; i++) begin
            if (m[i]) p = i;
        end
        sh = p - 23;
        if (-149 - e > sh) sh = -149 - e;
        if (sh > 0) begin
            q = m >> sh;
            g = m[sh-1];
            st = (m & ((t_wide'(1) << (sh - 1)) - 1)) != '0;
            if (g && (st || q[0])) q = q + 1;
        end else begin
            q = m << (-sh);
        end
        qe = e + sh;
        if (q[24]) begin
            q = q >> 1;
            qe++;
        end
        if (q[23]) begin
            if (qe + 150 >= 255) return {s, 8'hFF, 23'd0};
            return {s, 8'(qe + 150), q[22:0]};
        end
        return {s, 8'd0, q[22:0]};
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        t_wide ma, mb, m;
        int ea, eb;
        logic [31:0] t;
        logic s;
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
        if (is_zero(a)) return b;
        if (is_zero(b)) return a;
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        if (ea < eb) begin
            t = a; a = b; b = t;
            fp_split(a, ma, ea);
            fp_split(b, mb, eb);
        end
        ma = ma << (ea - eb);
        if (a[31] == b[31]) begin
            m = ma + mb;
            s = a[31];
        end else if (ma > mb) begin
            m = ma - mb;
            s = a[31];
        end else if (mb > ma) begin
            m = mb - ma;
            s = b[31];
        end else begin
            return 32'd0;
        end
        return fp_round(s, m, eb);
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        t_wide ma, mb;
        int ea, eb;
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return CANON_NAN;
        if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
        if (is_zero(a) || is_zero(b)) return {s, 31'd0};
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        return fp_round(s, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] fp_div(logic [31:0] a, logic [31:0] b);
        t_wide ma, mb, q;
        int ea, eb, e;
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b)) return CANON_NAN;
        if (is_inf(a)) return {s, 8'hFF, 23'd0};
        if (is_inf(b) || is_zero(a)) return {s, 31'd0};
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        ma = ma << 100;
        q = ma / mb;
        e = ea - eb - 100;
        if ((ma % mb) != '0) begin
            q = (q << 1) | t_wide'(1);
            e--;
        end
        return fp_round(s, q, e);
    endfunction

    function automatic t_out_req acc_apply(t_in_req r);
        t_out_req o;
        o.status = STATUS_OK;
        case (r.cmd)
            CMD_SET: acc_model = r.operand;
            CMD_ADD: acc_model = fp_add(acc_model, r.operand);
            CMD_SUB: acc_model = fp_add(acc_model, {~r.operand[31], r.operand[30:0]});
            CMD_MUL: acc_model = fp_mul(acc_model, r.operand);
            CMD_DIV: begin
                if (is_zero(r.operand)) o.status = STATUS_DIV0;
                else acc_model = fp_div(acc_model, r.operand);
            end
            CMD_READ: ;
            default: o.status = STATUS_BAD_CMD;
        endcase
        o.acc_value = acc_model;
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(9))
            0: x[30:0] = '0;
            1: x[30:0] = {8'hFF, 23'd0};
            2: x[30:23] = 8'hFF;
            3: x[30:23] = 8'h00;
            4: x[30:23] = 8'(127 + $urandom_range(0, 10) - 5);
            5: x[30:23] = 8'($urandom_range(1, 30));
            6: x[30:23] = 8'($urandom_range(225, 254));
            7: x[30:0] = acc_model[30:0] ^ 31'($urandom_range(3));
            default: ;
        endcase
        return x;
    endfunction

    function automatic void push_cmd(logic [CMD_W-1:0] c, logic [31:0] v);
        t_in_req r;
        r.cmd = c;
        r.operand = v;
        cmd_queue.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("float_accumulator_alu test failed");
            $finish;
        end
    end

    // monitor: check results, then predict for the accepted request
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out_req);
                    errors++;
                end else begin
                    want = result_queue.pop_front();
                    if (o_out_req.acc_value !== want.acc_value) begin
                        $display("%0t: acc_value expected %h actual %h", $time,
                                 want.acc_value, o_out_req.acc_value);
                        errors++;
                    end
                    if (o_out_req.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, o_out_req.status);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) result_queue.push_back(acc_apply(i_in_req));
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            if (!i_in_valid || !o_in_stall_at_edge) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_req <= cmd_queue.pop_front();
                    i_in_valid <= 1'b1;
                    issued <= issued + 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) o_in_stall_at_edge <= o_in_stall;

    always @(negedge i_clk) begin
        int total;
        total = issued + cmd_queue.size();
        if (issued > 2 * total / 3) begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
        end else if (issued > total / 3) begin
            tx_idle_pct <= 51;
            rx_idle_pct <= 33;
        end
    end

    initial begin
        push_cmd(CMD_READ, 32'h0);
        push_cmd(CMD_SET, 32'hFFFF_FFFF);
        push_cmd(CMD_SET, 32'h7F80_0001);
        push_cmd(CMD_ADD, 32'h3F80_0000);
        push_cmd(CMD_SET, 32'h7F7F_FFFF);
        push_cmd(CMD_ADD, 32'h7F7F_FFFF);
        push_cmd(CMD_SUB, 32'hFF80_0000);
        push_cmd(CMD_ADD, 32'hFF80_0000);
        push_cmd(CMD_SET, 32'h0000_0001);
        push_cmd(CMD_MUL, 32'h3F00_0000);
        push_cmd(CMD_SET, 32'h0080_0000);
        push_cmd(CMD_SUB, 32'h0000_0001);
        push_cmd(CMD_DIV, 32'h0000_0000);
        push_cmd(CMD_DIV, 32'h8000_0000);
        push_cmd(CMD_DIV, 32'h0000_0003);
        push_cmd(CMD_DIV, 32'h7FC0_1234);
        push_cmd(CMD_SET, 32'h4049_0FDB);
        push_cmd(CMD_SUB, 32'h4049_0FDB);
        push_cmd(CMD_MUL, 32'hFF80_0000);
        push_cmd(CMD_SET, 32'h8000_0000);
        push_cmd(CMD_ADD, 32'h8000_0000);
        push_cmd(CMD_BAD_LO, 32'h1234_5678);
        push_cmd(CMD_BAD_HI, 32'h8765_4321);
        push_cmd(CMD_SET, 32'h3F80_0000);
        push_cmd(CMD_DIV, 32'h4040_0000);
        for (int k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(19))
                0, 1:    push_cmd(CMD_SET, rand_operand());
                2:       push_cmd(CMD_READ, $urandom);
                3:       push_cmd($urandom_range(1) ? CMD_BAD_HI : CMD_BAD_LO, $urandom);
                4, 5, 6, 7: push_cmd(CMD_ADD, rand_operand());
                8, 9, 10:   push_cmd(CMD_SUB, rand_operand());
                11, 12, 13, 14: push_cmd(CMD_MUL, rand_operand());
                default: push_cmd(CMD_DIV, rand_operand());
            endcase
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || i_in_valid || result_queue.size() != 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("float_accumulator_alu test passed");
        end else begin
            $display("float_accumulator_alu test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
